>>> hdl/hlbc_pkg.sv
// Package: shared types and constants of the hashed LRU buffer cache core.
`timescale 1ns / 1ps
package hlbc_pkg;
  localparam int BUCKETS_DEF = 16;
  localparam int WAYS_DEF    = 8;

  localparam logic [1:0] FUNC_GET     = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_PIN     = 2'd2;
  localparam logic [1:0] FUNC_UNPIN   = 2'd3;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_NOFREE  = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_CNT_ERR = 3'd4;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // result of one operation
  typedef struct packed {
    logic [2:0] status;
    logic [2:0] way;
    logic       need_fill;
    logic [7:0] count;
  } result_t;
endpackage

>>> hdl/hlbc_row_mem.sv
// Bucket row memory: one row per bucket, registered read.
`timescale 1ns / 1ps
module hlbc_row_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [WIDTH-1:0]          wr_data,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [WIDTH-1:0]          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> hdl/hashed_lru_buffer_cache_core.sv
// Top level: tag and LRU policy engine of a hashed set-associative buffer cache.
`timescale 1ns / 1ps
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  request | in_valid/in_ready, func, device,           | in
//          | block_number, way_in                       |
//  result  | out_valid/out_ready, status, way_out,      | out
//          | need_fill, count_out                       |
//
// Each request passes accept, row read (registered memory read), then
// compare/update with write back and result register in the same cycle. The
// single bucket-row memory port sets this sequence; one request is in flight,
// so no same-bucket hazard.
// Reset clears the valid bits of all rows at once; a row not yet written reads
// as its reset contents (zero tags and counts, way w at rank w).
// A waiting result holds the request in the update cycle until it is taken.
//
module hashed_lru_buffer_cache_core
  import hlbc_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [2:0]  way_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [2:0]  way_out,
  output logic        need_fill,
  output logic [7:0]  count_out
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  // per way: device, block, filled, count, rank
  localparam int EW = 8 + 32 + 1 + 8 + WW;
  localparam int RW = EW * WAYS;

  typedef logic [255:0][7:0] mod_tab_t;

  // residue table for byte j of the block number: (v * 256**j) mod BUCKETS
  function automatic mod_tab_t mod_table(int j);
    mod_tab_t t;
    int wgt;
    wgt = 1 % BUCKETS;
    for (int k = 0; k < 8 * j; k++) wgt = (wgt * 2) % BUCKETS;
    for (int v = 0; v < 256; v++) t[v] = 8'((v * wgt) % BUCKETS);
    return t;
  endfunction

  localparam mod_tab_t MOD_TAB0 = mod_table(0);
  localparam mod_tab_t MOD_TAB1 = mod_table(1);
  localparam mod_tab_t MOD_TAB2 = mod_table(2);
  localparam mod_tab_t MOD_TAB3 = mod_table(3);

  typedef struct packed {
    logic [7:0]    dev;
    logic [31:0]   blk;
    logic          fil;
    logic [7:0]    cnt;
    logic [WW-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_UPDATE} state_t;

  state_t            state;
  logic [1:0]        r_func;
  logic [7:0]        r_dev;
  logic [31:0]       r_blk;
  logic [2:0]        r_way;
  logic [BW-1:0]     r_bucket;
  logic [BUCKETS-1:0] row_valid;
  logic              row_ok;
  logic              wr_en;
  logic [RW-1:0]     wr_data;
  logic [RW-1:0]     rd_data;
  entry_t            row     [WAYS];
  entry_t            row_new [WAYS];
  result_t           res;
  result_t           out_reg;
  logic              out_full;
  logic [BW-1:0]     in_bucket;
  logic [7:0]        part_sum;

  // bucket = block mod BUCKETS: sum the byte residues (below 4 * BUCKETS),
  // then fold the sum once more through the low-byte table
  assign part_sum = MOD_TAB0[block_number[7:0]] + MOD_TAB1[block_number[15:8]] +
                    MOD_TAB2[block_number[23:16]] + MOD_TAB3[block_number[31:24]];
  assign in_bucket = MOD_TAB0[part_sum][BW-1:0];

  hlbc_row_mem #(.DEPTH(BUCKETS), .WIDTH(RW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (r_bucket),
    .wr_data (wr_data),
    .rd_addr (r_bucket),
    .rd_data (rd_data)
  );

  // unpack row; substitute reset contents for a never-written row
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (row_ok) begin
        row[w] = rd_data[w*EW +: EW];
      end else begin
        row[w] = '0;
        row[w].rank = WW'(w);
      end
    end
  end

  // compare all ways, pick hit and victim, build the new row
  always_comb begin
    logic          found, victim_ok;
    logic [WW-1:0] fw, vw, wi, r;
    logic [7:0]    c;
    found = 1'b0; victim_ok = 1'b0; fw = '0; vw = '0;
    wi = WW'(r_way);
    for (int w = 0; w < WAYS; w++) begin
      row_new[w] = row[w];
      if (row[w].dev == r_dev && row[w].blk == r_blk) begin
        if (!found || row[w].rank > row[fw].rank) fw = WW'(w);
        found = 1'b1;
      end
      if (row[w].cnt == 8'd0) begin
        if (!victim_ok || row[w].rank < row[vw].rank) vw = WW'(w);
        victim_ok = 1'b1;
      end
    end
    res = '0;
    res.status = ST_DONE;
    res.way = r_way;
    c = '0; r = '0;
    if (r_func == FUNC_GET) begin
      if (found) begin
        c = row[fw].cnt;
        if (c == COUNT_MAX) begin
          res.status = ST_CNT_ERR;
        end else begin
          c = c + 8'd1;
          res.status = ST_HIT;
        end
        res.need_fill = ~row[fw].fil;
        row_new[fw].cnt = c;
        row_new[fw].fil = 1'b1;
        res.way = 3'(fw);
        res.count = c;
      end else if (victim_ok) begin
        row_new[vw].dev = r_dev;
        row_new[vw].blk = r_blk;
        row_new[vw].cnt = 8'd1;
        row_new[vw].fil = 1'b1;
        res.status = ST_MISS;
        res.need_fill = 1'b1;
        res.way = 3'(vw);
        res.count = 8'd1;
      end else begin
        res.status = ST_NOFREE;
        res.way = '0;
      end
    end else if (32'(r_way) >= 32'(WAYS)) begin
      res.status = ST_CNT_ERR;
    end else begin
      c = row[wi].cnt;
      if (r_func == FUNC_PIN) begin
        if (c == COUNT_MAX) res.status = ST_CNT_ERR;
        else c = c + 8'd1;
      end else if (c == 8'd0) begin
        res.status = ST_CNT_ERR;
      end else begin
        c = c - 8'd1;
        if (r_func == FUNC_RELEASE && c == 8'd0) begin
          // move to most recent: shift down the ranks above it
          r = row[wi].rank;
          for (int w = 0; w < WAYS; w++) begin
            if (row[w].rank > r) row_new[w].rank = row[w].rank - WW'(1);
          end
          row_new[wi].rank = WW'(WAYS - 1);
        end
      end
      row_new[wi].cnt = c;
      res.count = c;
    end
    for (int w = 0; w < WAYS; w++) wr_data[w*EW +: EW] = row_new[w];
  end

  assign wr_en    = (state == S_UPDATE) && !out_full;
  assign in_ready = (state == S_IDLE);
  assign out_valid = out_full;
  assign status    = out_reg.status;
  assign way_out   = out_reg.way;
  assign need_fill = out_reg.need_fill;
  assign count_out = out_reg.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_valid <= '0;
      out_full  <= 1'b0;
      row_ok    <= 1'b0;
    end else begin
      if (out_full && out_ready) out_full <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_func   <= func;
            r_dev    <= device;
            r_blk    <= block_number;
            r_way    <= way_in;
            r_bucket <= in_bucket;
            state    <= S_READ;
          end
        end
        S_READ: begin
          // memory read issued this cycle; capture row validity alongside
          row_ok <= row_valid[r_bucket];
          state  <= S_UPDATE;
        end
        S_UPDATE: begin
          // hold until the result register is free
          if (!out_full) begin
            out_reg  <= res;
            out_full <= 1'b1;
            row_valid[r_bucket] <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/hlbc_checker.sv
// Port-level checker for the buffer cache core, bound to the top level.
`timescale 1ns / 1ps
module hlbc_checker
  import hlbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [2:0] way_out,
  input logic       need_fill,
  input logic [7:0] count_out
);
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_CNT_ERR) else $error("bad status");
  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_NOFREE |-> way_out == 3'd0 && count_out == 8'd0 && !need_fill)
    else $error("no-free result not zeroed");
  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MISS |-> count_out == 8'd1 && need_fill)
    else $error("miss result wrong");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count_out))
    else $error("result dropped");
  a_one_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second request in flight");
endmodule

bind hashed_lru_buffer_cache_core hlbc_checker u_hlbc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .way_out(way_out), .need_fill(need_fill), .count_out(count_out)
);
